### hdl/scm_pkg.sv
// Shared types, reply codes and command words of the serial command line matcher.
package scm_pkg;

    // Reply codes carried in the result.
    localparam logic [2:0] REPLY_LED1_ON  = 3'd0;
    localparam logic [2:0] REPLY_LED1_OFF = 3'd1;
    localparam logic [2:0] REPLY_BEEP_ON  = 3'd2;
    localparam logic [2:0] REPLY_BEEP_OFF = 3'd3;
    localparam logic [2:0] REPLY_UNKNOWN  = 3'd4;

    // Framing bytes.
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Command words, right-aligned, first character in the highest used byte.
    localparam int CMD_BITS      = 64;
    localparam int CMD_SHORT_LEN = 7;
    localparam int CMD_LONG_LEN  = 8;
    localparam int IDX_W         = 3;

    localparam logic [CMD_BITS-1:0] WORD_LED1_ON  = "led1 on";
    localparam logic [CMD_BITS-1:0] WORD_LED1_OFF = "led1 off";
    localparam logic [CMD_BITS-1:0] WORD_BEEP_ON  = "beep on";
    localparam logic [CMD_BITS-1:0] WORD_BEEP_OFF = "beep off";

    // Match flags of the two candidate words of one length.
    typedef struct packed {
        logic led;
        logic beep;
    } scm_match_t;

    // Character at position idx of a command word of the given length class.
    function automatic logic [7:0] cmd_char(input logic [CMD_BITS-1:0] word,
                                            input logic [IDX_W-1:0] idx,
                                            input logic long_word);
        int pos;
        pos = (long_word ? CMD_LONG_LEN : CMD_SHORT_LEN) - 1 - int'(idx);
        return word[pos*8 +: 8];
    endfunction

endpackage

### hdl/scm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 31,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### hdl/scm_cmp.sv
// Shared character compare unit that accumulates the match flags of a line.
module scm_cmp
    import scm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             en,
    input  logic             long_word,
    input  logic [IDX_W-1:0] idx,
    input  logic [7:0]       ch,
    output scm_match_t       match
);

    scm_match_t match_reg;
    scm_match_t match_next;
    logic [7:0] want_led;
    logic [7:0] want_beep;

    // Expected characters of the two candidates at this position.
    assign want_led  = cmd_char(long_word ? WORD_LED1_OFF : WORD_LED1_ON, idx, long_word);
    assign want_beep = cmd_char(long_word ? WORD_BEEP_OFF : WORD_BEEP_ON, idx, long_word);

    // A candidate stays alive only while every character agrees.
    always_comb
    begin
        match_next = match_reg;
        if (start)
        begin
            match_next.led  = 1'b1;
            match_next.beep = 1'b1;
        end
        else if (en)
        begin
            match_next.led  = match_reg.led  & (ch == want_led);
            match_next.beep = match_reg.beep & (ch == want_beep);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign match = match_reg;

endmodule

### hdl/serial_command_line_matcher.sv
// Top level: line buffer, compare sequencer and result register.
// A carriage return, a kept character or an empty line end is taken in the idle state.
// A line end with seven or eight kept characters passes through a read state and a
// compare state for each character, as the buffer RAM's read is registered, and then
// the done state; any other non-empty line end goes straight to the done state. A line
// end waits in the done state while an earlier result is still stalled at the output.
// Reset (rst_n, asynchronous, active low) empties the line, turns LED1 and the beeper
// off and drops any waiting result; the buffer RAM is not cleared.
module serial_command_line_matcher
    import scm_pkg::*;
#(
    parameter int BUFFER_BYTES = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [2:0] reply_code, [3] led1_level, [4] beep_level, [7:5] zero
);

    localparam int LINE_CAP = BUFFER_BYTES - 1;
    localparam int LEN_W    = $clog2(BUFFER_BYTES);
    localparam int ADDR_W   = $clog2(LINE_CAP);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             long_reg, long_next;
    logic             led_reg, led_next;
    logic             beep_reg, beep_next;
    logic             m_valid_reg, m_valid_next;
    logic [2:0]       code_reg, code_next;
    logic             out_led_reg, out_led_next;
    logic             out_beep_reg, out_beep_next;

    logic             accept;
    logic             is_full;
    logic             is_short;
    logic             is_long;
    logic             ram_we;
    logic [7:0]       ram_rdata;
    logic             cmp_start;
    logic             cmp_en;
    logic             last_char;
    logic             out_free;
    scm_match_t       match;

    assign accept   = s_tvalid & s_tready;
    assign is_full  = (len_reg == LEN_W'(LINE_CAP));
    assign is_short = (len_reg == LEN_W'(CMD_SHORT_LEN));
    assign is_long  = (len_reg == LEN_W'(CMD_LONG_LEN));
    assign out_free = ~m_valid_reg | m_tready;
    assign last_char = long_reg ? (idx_reg == IDX_W'(CMD_LONG_LEN - 1))
                                : (idx_reg == IDX_W'(CMD_SHORT_LEN - 1));

    assign s_tready  = (state_reg == ST_IDLE);
    assign ram_we    = accept && (s_tdata != CHAR_CR) && (s_tdata != CHAR_LF) && !is_full;
    assign cmp_start = accept && (s_tdata == CHAR_LF || is_full) && (is_short || is_long);
    assign cmp_en    = (state_reg == ST_CMP);

    // Line buffer.
    scm_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CAP)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (len_reg[ADDR_W-1:0]),
        .wr_data (s_tdata),
        .rd_addr (ADDR_W'(idx_reg)),
        .rd_data (ram_rdata)
    );

    // Shared character compare unit.
    scm_cmp u_cmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmp_start),
        .en        (cmp_en),
        .long_word (long_reg),
        .idx       (idx_reg),
        .ch        (ram_rdata),
        .match     (match)
    );

    // Sequencer: collect bytes, scan a line of seven or eight characters, then post the result.
    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        long_next     = long_reg;
        led_next      = led_reg;
        beep_next     = beep_reg;
        m_valid_next  = m_valid_reg & ~m_tready;
        code_next     = code_reg;
        out_led_next  = out_led_reg;
        out_beep_next = out_beep_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (ram_we)
                begin
                    len_next = len_reg + LEN_W'(1);
                end
                else if (accept && s_tdata != CHAR_CR && len_reg != '0)
                begin
                    // Line end, or a byte that overflows a full line, with a non-empty line.
                    idx_next  = '0;
                    long_next = is_long;
                    if (is_short || is_long)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (last_char)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    code_next = REPLY_UNKNOWN;
                    if (is_short && match.led)
                    begin
                        code_next = REPLY_LED1_ON;
                        led_next  = 1'b1;
                    end
                    else if (is_long && match.led)
                    begin
                        code_next = REPLY_LED1_OFF;
                        led_next  = 1'b0;
                    end
                    else if (is_short && match.beep)
                    begin
                        code_next = REPLY_BEEP_ON;
                        beep_next = 1'b1;
                    end
                    else if (is_long && match.beep)
                    begin
                        code_next = REPLY_BEEP_OFF;
                        beep_next = 1'b0;
                    end
                    out_led_next  = led_next;
                    out_beep_next = beep_next;
                    m_valid_next  = 1'b1;
                    len_next      = '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            led_reg     <= 1'b0;
            beep_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            led_reg     <= led_next;
            beep_reg    <= beep_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        long_reg     <= long_next;
        code_reg     <= code_next;
        out_led_reg  <= out_led_next;
        out_beep_reg <= out_beep_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_beep_reg, out_led_reg, code_reg};

endmodule

### hdl/scm_checker.sv
// Port-level checker of the serial command line matcher and its bind.
module scm_port_checker
    import scm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reply code is one of the defined codes and padding is zero.
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] == REPLY_LED1_ON || m_tdata[2:0] == REPLY_LED1_OFF
                   || m_tdata[2:0] == REPLY_BEEP_ON || m_tdata[2:0] == REPLY_BEEP_OFF
                   || m_tdata[2:0] == REPLY_UNKNOWN) && m_tdata[7:5] == 3'b000)
        else $error("bad reply code or padding");

    // LED level agrees with an LED command.
    a_led: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] == REPLY_LED1_ON || m_tdata[2:0] == REPLY_LED1_OFF)
        |-> m_tdata[3] == (m_tdata[2:0] == REPLY_LED1_ON))
        else $error("LED level disagrees with reply");

    // Beeper level agrees with a beeper command.
    a_beep: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] == REPLY_BEEP_ON || m_tdata[2:0] == REPLY_BEEP_OFF)
        |-> m_tdata[4] == (m_tdata[2:0] == REPLY_BEEP_ON))
        else $error("beeper level disagrees with reply");

    // A carriage return never leads to a new result.
    a_cr: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata == CHAR_CR && !m_tvalid |=> !m_tvalid)
        else $error("result after carriage return");

endmodule

bind serial_command_line_matcher scm_port_checker u_scm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
